@@ hdl/tdss_pkg.sv @@
// Shared types, widths, status codes and saturation helpers of the tridiagonal solver.
package tdss_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 5;
   localparam int STAT_W = 2;
   localparam int ACC_W  = 66;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_PIVOT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ROWS  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_LEFT  = 1'b0;
   localparam logic CSR_RIGHT = 1'b1;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DEN,
      ST_MUL_NUM,
      ST_MUL_RB,
      ST_ACC_RB,
      ST_CHECK,
      ST_DIV_SUP,
      ST_DIV_RHS,
      ST_WRITE,
      ST_BS_MUL,
      ST_BS_UPD,
      ST_EM_RD,
      ST_EM_OUT,
      ST_ERR_OUT
   } state_type;

   // Clamp a wide signed value into the 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > ACC_W'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < ACC_W'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Magnitude of a signed 32-bit value as unsigned.
   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
      return r;
   endfunction

endpackage

@@ hdl/tdss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tdss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ hdl/tridiagonal_system_solver_unit.sv @@
// Top level of the tridiagonal (Thomas) solver: sequencer, shared multiplier and divider.
//
// Usage:
//  - Rows of the system are sent one per transfer on the req_ channel: raise start with
//    the four Q16.16 coefficients and last_row; the transfer happens when busy is low.
//  - Each row runs the forward sweep: three products on one shared 32x32 multiplier,
//    then two restoring divisions on one shared divider, one quotient bit per cycle.
//    Busy stays high after a transfer until the row is written back, so a new row is
//    not taken before the last one is through; the divisions take most of that time.
//    A zero pivot skips the divisions.
//  - On the row marked last_row the block back-substitutes (a multiply and an update
//    step per unknown before the last) and then emits x[0..n-1] in index order, one per
//    cycle after a read of x[0], on rsp_strobe. last_value marks the final result.
//  - A zero pivot or a row beyond MAX_UNKNOWNS makes the run end in one result with
//    status set, solution 0 and last_value 1.
//  - Write left_boundary (index 0) and right_boundary (index 1) on the csr_ port only while
//    the block is idle; the block does not enforce this. They take effect on the next row.
//  - Reset clears the row count, error code and sequencer, and restores the boundary
//    registers to 1.0 and 3.0. Stored sweep terms need no clearing.
//  - Results are shown for one cycle only; the receiver cannot stall them.
module tridiagonal_system_solver_unit
   import tdss_pkg::*;
#(
   parameter int MAX_UNKNOWNS = 32,
   parameter int FRAC_BITS    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // row input
   input  logic                     start,
   output logic                     busy,
   input  logic signed [DATA_W-1:0] req_sub_coef,
   input  logic signed [DATA_W-1:0] req_diag_coef,
   input  logic signed [DATA_W-1:0] req_super_coef,
   input  logic signed [DATA_W-1:0] req_rhs_value,
   input  logic                     req_last_row,
   // results
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_solution,
   output logic [IDX_W-1:0]         rsp_unknown_index,
   output logic                     rsp_last_value,
   output logic [STAT_W-1:0]        rsp_status,
   // configuration
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   localparam int AW  = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
   localparam int RCW = $clog2(MAX_UNKNOWNS + 1);
   localparam int QW  = DATA_W + FRAC_BITS;
   localparam int CW  = $clog2(QW);
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic [QW-1:0] QPOS_MAX = QW'(SAT_MAX);
   localparam logic [QW-1:0] QNEG_MAX = QW'(SAT_MAX) + QW'(1);

   // control state
   state_type              state_ff, state_in;
   logic [RCW-1:0]         row_count_ff, row_count_in;
   logic [STAT_W-1:0]      err_ff, err_in;
   logic signed [DATA_W-1:0] left_ff, right_ff;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   // datapath registers
   logic signed [DATA_W-1:0] sub_ff, sub_in, diag_ff, diag_in;
   logic signed [DATA_W-1:0] sup_ff, sup_in, rhs_ff, rhs_in;
   logic                   last_ff, last_in, row0_ff, row0_in;
   logic [AW-1:0]          addr_ff, addr_in, last_idx_ff, last_idx_in;
   logic signed [63:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0] den_ff, den_in, num_ff, num_in;
   logic signed [DATA_W-1:0] num_sat_ff, num_sat_in;
   logic [DATA_W-1:0]      dmag_ff, dmag_in;
   logic                   dneg_ff, dneg_in, qneg_ff, qneg_in;
   logic [DATA_W-1:0]      rem_ff, rem_in;
   logic [QW-1:0]          qd_ff, qd_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] q_sup_ff, q_sup_in, q_rhs_ff, q_rhs_in, x_ff, x_in;
   logic signed [DATA_W-1:0] sol_ff, sol_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   lastv_ff, lastv_in;
   logic [STAT_W-1:0]      stat_ff, stat_in;

   // memories
   logic                   we_super, we_rhs;
   logic [DATA_W-1:0]      wd_super, wd_rhs, rd_super, rd_rhs;

   // shared arithmetic
   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  bs_val;
   logic [DATA_W:0]          rem_sh;
   logic                     ge;
   logic [DATA_W-1:0]        rem_step;
   logic [QW-1:0]            qd_step;
   logic signed [DATA_W-1:0] q_final;
   logic                     accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   tdss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_super_ram (
      .clock (clock),
      .we    (we_super),
      .waddr (addr_ff),
      .wdata (wd_super),
      .raddr (addr_in),
      .rdata (rd_super)
   );

   tdss_ram #(.WIDTH(DATA_W), .DEPTH(MAX_UNKNOWNS)) u_rhs_ram (
      .clock (clock),
      .we    (we_rhs),
      .waddr (addr_ff),
      .wdata (wd_rhs),
      .raddr (addr_in),
      .rdata (rd_rhs)
   );

   // Rounded product: add half an LSB, then floor shift.
   assign rnd    = (ACC_W'(prod_ff) + HALF) >>> FRAC_BITS;
   assign bs_val = ACC_W'($signed(rd_rhs)) - rnd;

   // One restoring division step.
   assign rem_sh   = {rem_ff, qd_ff[QW-1]};
   assign ge       = (rem_sh >= {1'b0, dmag_ff});
   assign rem_step = ge ? DATA_W'(rem_sh - {1'b0, dmag_ff}) : DATA_W'(rem_sh);
   assign qd_step  = {qd_ff[QW-2:0], ge};

   always_comb begin
      if (qneg_ff) begin
         q_final = (qd_step > QNEG_MAX) ? SAT_MIN : DATA_W'(-qd_step);
      end else begin
         q_final = (qd_step > QPOS_MAX) ? SAT_MAX : DATA_W'(qd_step);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (row_count_ff == RCW'(MAX_UNKNOWNS)) begin
                  state_in = req_last_row ? ST_ERR_OUT : ST_IDLE;
               end else begin
                  state_in = ST_MUL_DEN;
               end
            end
         end
         ST_MUL_DEN: state_in = ST_MUL_NUM;
         ST_MUL_NUM: state_in = ST_MUL_RB;
         ST_MUL_RB:  state_in = ST_ACC_RB;
         ST_ACC_RB:  state_in = ST_CHECK;
         ST_CHECK:   state_in = (den_ff == '0) ? ST_WRITE : ST_DIV_SUP;
         ST_DIV_SUP: begin
            if (cnt_ff == CW'(QW - 1)) begin
               state_in = ST_DIV_RHS;
            end
         end
         ST_DIV_RHS: begin
            if (cnt_ff == CW'(QW - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (err_ff != STATUS_OK) begin
               state_in = ST_ERR_OUT;
            end else if (addr_ff == '0) begin
               state_in = ST_EM_RD;
            end else begin
               state_in = ST_BS_MUL;
            end
         end
         ST_BS_MUL: state_in = ST_BS_UPD;
         ST_BS_UPD: state_in = (addr_ff == '0) ? ST_EM_RD : ST_BS_MUL;
         ST_EM_RD:  state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (addr_ff == last_idx_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR_OUT: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      row_count_in  = row_count_ff;
      err_in        = err_ff;
      rsp_strobe_in = 1'b0;
      sub_in = sub_ff; diag_in = diag_ff; sup_in = sup_ff; rhs_in = rhs_ff;
      last_in = last_ff; row0_in = row0_ff;
      addr_in = addr_ff; last_idx_in = last_idx_ff;
      mul_a = '0; mul_b = '0;
      prod_in = prod_ff;
      den_in = den_ff; num_in = num_ff; num_sat_in = num_sat_ff;
      dmag_in = dmag_ff; dneg_in = dneg_ff; qneg_in = qneg_ff;
      rem_in = rem_ff; qd_in = qd_ff; cnt_in = cnt_ff;
      q_sup_in = q_sup_ff; q_rhs_in = q_rhs_ff; x_in = x_ff;
      sol_in = sol_ff; idx_in = idx_ff; lastv_in = lastv_ff; stat_in = stat_ff;
      we_super = 1'b0; we_rhs = 1'b0;
      wd_super = q_sup_ff; wd_rhs = q_rhs_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sub_in  = req_sub_coef;
               diag_in = req_diag_coef;
               sup_in  = req_super_coef;
               rhs_in  = req_rhs_value;
               last_in = req_last_row;
               row0_in = (row_count_ff == '0);
               // fetch the previous row's terms
               addr_in = AW'(row_count_ff - RCW'(1));
               if (row_count_ff == RCW'(MAX_UNKNOWNS) && err_ff == STATUS_OK) begin
                  err_in = STATUS_ROWS;
               end
            end
         end
         ST_MUL_DEN: begin
            mul_a   = sub_ff;
            mul_b   = row0_ff ? '0 : $signed(rd_super);
            prod_in = 64'(mul_a) * 64'(mul_b);
         end
         ST_MUL_NUM: begin
            den_in  = ACC_W'(diag_ff) - rnd;
            mul_a   = sub_ff;
            mul_b   = row0_ff ? left_ff : $signed(rd_rhs);
            prod_in = 64'(mul_a) * 64'(mul_b);
         end
         ST_MUL_RB: begin
            num_in  = ACC_W'(rhs_ff) - rnd;
            mul_a   = sup_ff;
            mul_b   = last_ff ? right_ff : '0;
            prod_in = 64'(mul_a) * 64'(mul_b);
            // point at this row for the write-back
            addr_in = AW'(row_count_ff);
         end
         ST_ACC_RB: begin
            num_in = num_ff - rnd;
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               q_sup_in = '0;
               q_rhs_in = '0;
               if (err_ff == STATUS_OK) begin
                  err_in = STATUS_PIVOT;
               end
            end else begin
               num_sat_in = sat32(num_ff);
               dmag_in    = mag32(sat32(den_ff));
               dneg_in    = den_ff[ACC_W-1];
               qneg_in    = sup_ff[DATA_W-1] ^ den_ff[ACC_W-1];
               rem_in     = '0;
               qd_in      = {mag32(sup_ff), FRAC_BITS'(0)};
               cnt_in     = '0;
            end
         end
         ST_DIV_SUP: begin
            rem_in = rem_step;
            qd_in  = qd_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(QW - 1)) begin
               q_sup_in = q_final;
               // load the right-hand-side division
               rem_in   = '0;
               qd_in    = {mag32(num_sat_ff), FRAC_BITS'(0)};
               cnt_in   = '0;
               qneg_in  = num_sat_ff[DATA_W-1] ^ dneg_ff;
            end
         end
         ST_DIV_RHS: begin
            rem_in = rem_step;
            qd_in  = qd_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(QW - 1)) begin
               q_rhs_in = q_final;
            end
         end
         ST_WRITE: begin
            we_super     = 1'b1;
            we_rhs       = 1'b1;
            row_count_in = row_count_ff + RCW'(1);
            last_idx_in  = addr_ff;
            x_in         = q_rhs_ff;
            if (last_ff && err_ff == STATUS_OK && addr_ff != '0) begin
               addr_in = addr_ff - AW'(1);
            end
         end
         ST_BS_MUL: begin
            mul_a   = $signed(rd_super);
            mul_b   = x_ff;
            prod_in = 64'(mul_a) * 64'(mul_b);
         end
         ST_BS_UPD: begin
            x_in   = sat32(bs_val);
            wd_rhs = sat32(bs_val);
            we_rhs = 1'b1;
            if (addr_ff != '0) begin
               addr_in = addr_ff - AW'(1);
            end
         end
         ST_EM_RD: begin
            addr_in = '0;
         end
         ST_EM_OUT: begin
            rsp_strobe_in = 1'b1;
            sol_in        = $signed(rd_rhs);
            idx_in        = IDX_W'(addr_ff);
            lastv_in      = (addr_ff == last_idx_ff);
            stat_in       = STATUS_OK;
            if (addr_ff == last_idx_ff) begin
               row_count_in = '0;
               err_in       = STATUS_OK;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_ERR_OUT: begin
            rsp_strobe_in = 1'b1;
            sol_in        = '0;
            idx_in        = '0;
            lastv_in      = 1'b1;
            stat_in       = err_ff;
            row_count_in  = '0;
            err_in        = STATUS_OK;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_count_ff  <= '0;
         err_ff        <= STATUS_OK;
         rsp_strobe_ff <= 1'b0;
         left_ff       <= 32'sd65536;
         right_ff      <= 32'sd196608;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         err_ff        <= err_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we && csr_index == CSR_LEFT) begin
            left_ff <= $signed(csr_wdata);
         end
         if (csr_we && csr_index == CSR_RIGHT) begin
            right_ff <= $signed(csr_wdata);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sub_ff <= sub_in; diag_ff <= diag_in; sup_ff <= sup_in; rhs_ff <= rhs_in;
      last_ff <= last_in; row0_ff <= row0_in;
      addr_ff <= addr_in; last_idx_ff <= last_idx_in;
      prod_ff <= prod_in;
      den_ff <= den_in; num_ff <= num_in; num_sat_ff <= num_sat_in;
      dmag_ff <= dmag_in; dneg_ff <= dneg_in; qneg_ff <= qneg_in;
      rem_ff <= rem_in; qd_ff <= qd_in; cnt_ff <= cnt_in;
      q_sup_ff <= q_sup_in; q_rhs_ff <= q_rhs_in; x_ff <= x_in;
      sol_ff <= sol_in; idx_ff <= idx_in; lastv_ff <= lastv_in; stat_ff <= stat_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_solution      = sol_ff;
   assign rsp_unknown_index = idx_ff;
   assign rsp_last_value    = lastv_ff;
   assign rsp_status        = stat_ff;

`ifndef SYNTHESIS
   a_row_count_bound: assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= RCW'(MAX_UNKNOWNS))
      else $error("row count beyond capacity");

   a_error_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_status != STATUS_OK |-> rsp_last_value)
      else $error("error result not marked final");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_value |-> row_count_ff == '0 && err_ff == STATUS_OK)
      else $error("run state not cleared at final result");

   a_div_ends_in_divider: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV_SUP && cnt_ff == CW'(QW - 1) |=> state_ff == ST_DIV_RHS)
      else $error("divider sequence broken");
`endif

endmodule

@@ tb/sv/tridiagonal_system_solver_unit_test.sv @@
// Self-checking testbench of the tridiagonal system solver unit.
`timescale 1ns / 100ps

module tridiagonal_system_solver_unit_test
   import tdss_pkg::*;
();

   localparam int  N_UNK      = 32;
   localparam int  RANDOM_ROWS = 420;
   localparam int  LIMIT      = 400000;
   localparam int  DRAIN      = 200;
   localparam logic signed [DATA_W-1:0] ONE = 32'sd65536;

   typedef struct {
      logic signed [DATA_W-1:0] solution;
      logic [IDX_W-1:0]         index;
      logic                     last;
      logic [STAT_W-1:0]        status;
   } solution_type;

   // One row of the directed table; typed marks rows whose result is written out by hand.
   typedef struct {
      logic signed [DATA_W-1:0] sub;
      logic signed [DATA_W-1:0] diag;
      logic signed [DATA_W-1:0] sup;
      logic signed [DATA_W-1:0] rhs;
      logic                     last;
      logic                     typed;
      logic signed [DATA_W-1:0] x;
      logic [STAT_W-1:0]        status;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [DATA_W-1:0] req_sub_coef = '0;
   logic signed [DATA_W-1:0] req_diag_coef = '0;
   logic signed [DATA_W-1:0] req_super_coef = '0;
   logic signed [DATA_W-1:0] req_rhs_value = '0;
   logic req_last_row = 1'b0;
   logic rsp_strobe;
   logic signed [DATA_W-1:0] rsp_solution;
   logic [IDX_W-1:0] rsp_unknown_index;
   logic rsp_last_value;
   logic [STAT_W-1:0] rsp_status;
   logic csr_we = 1'b0;
   logic csr_index = CSR_LEFT;
   logic [DATA_W-1:0] csr_wdata = '0;

   tridiagonal_system_solver_unit DUT (.*);

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: boundaries, stored sweep terms, row count and sticky error.
   longint left_bound, right_bound;
   longint sweep_super[N_UNK];
   longint sweep_rhs[N_UNK];
   int unsigned rows_seen;
   logic [STAT_W-1:0] run_error;

   solution_type pending_solutions[$];
   int errors = 0;
   int cycles = 0;
   int rows_sent = 0;
   int systems_solved = 0;
   int solutions_seen = 0;
   int error_runs = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q16.16 product, round to nearest with ties upward.
   function automatic longint fx_mul(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   // Q16.16 quotient truncated toward zero, then clamped.
   function automatic longint fx_div(longint num, longint den);
      longint scaled;
      scaled = num * 64'sd65536;
      return clamp32(scaled / den);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // Advance the forward sweep by one row; on the last row back-substitute into sols.
   task automatic sweep_row(input row_type r, output solution_type sols[$]);
      longint den, num, x[N_UNK];
      int unsigned i, n;
      solution_type s;
      sols = {};
      if (rows_seen >= N_UNK) begin
         if (run_error == STATUS_OK) run_error = STATUS_ROWS;
      end else begin
         i = rows_seen;
         if (i == 0) begin
            den = r.diag;
            num = longint'(r.rhs) - fx_mul(r.sub, left_bound);
         end else begin
            den = longint'(r.diag) - fx_mul(r.sub, sweep_super[i-1]);
            num = longint'(r.rhs) - fx_mul(r.sub, sweep_rhs[i-1]);
         end
         if (r.last) num -= fx_mul(r.sup, right_bound);
         if (den == 0) begin
            if (run_error == STATUS_OK) run_error = STATUS_PIVOT;
            sweep_super[i] = 0;
            sweep_rhs[i] = 0;
         end else begin
            den = clamp32(den);
            sweep_super[i] = fx_div(r.sup, den);
            sweep_rhs[i] = fx_div(clamp32(num), den);
         end
         rows_seen = i + 1;
      end
      if (!r.last) return;
      if (run_error != STATUS_OK) begin
         s = '{solution: '0, index: '0, last: 1'b1, status: run_error};
         sols.push_back(s);
      end else begin
         n = rows_seen;
         x[n-1] = sweep_rhs[n-1];
         for (i = n - 1; i > 0; i--)
            x[i-1] = clamp32(sweep_rhs[i-1] - fx_mul(sweep_super[i-1], x[i]));
         for (i = 0; i < n; i++) begin
            s = '{solution: x[i][DATA_W-1:0], index: i[IDX_W-1:0], last: (i == n - 1),
                  status: STATUS_OK};
            sols.push_back(s);
         end
      end
      rows_seen = 0;
      run_error = STATUS_OK;
   endtask

   // Send one row after a random gap; keep start high when the next row follows at once.
   task automatic send_row(input row_type r);
      int gap;
      solution_type sols[$];
      solution_type s;
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_sub_coef <= r.sub;
      req_diag_coef <= r.diag;
      req_super_coef <= r.sup;
      req_rhs_value <= r.rhs;
      req_last_row <= r.last;
      do @(posedge clock); while (busy);
      rows_sent++;
      sweep_row(r, sols);
      if (r.typed) begin
         s = '{solution: r.x, index: '0, last: 1'b1, status: r.status};
         pending_solutions.push_back(s);
      end else begin
         foreach (sols[k]) pending_solutions.push_back(sols[k]);
      end
   endtask

   // Hold off until every result has come, then let the block settle before a write.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_boundaries(input logic [DATA_W-1:0] lb, input logic [DATA_W-1:0] rb);
      csr_we <= 1'b1;
      csr_index <= CSR_LEFT;
      csr_wdata <= lb;
      @(posedge clock);
      csr_index <= CSR_RIGHT;
      csr_wdata <= rb;
      @(posedge clock);
      csr_we <= 1'b0;
      left_bound = longint'(signed'(lb));
      right_bound = longint'(signed'(rb));
   endtask

   // Coefficient for random rows: mostly well-conditioned, some raw, some extremes.
   function automatic logic signed [DATA_W-1:0] pick_coef(int mode, bit is_diag);
      logic signed [DATA_W-1:0] v;
      case (mode)
         0: begin
            if (is_diag) begin
               v = $urandom_range(2 * 65536, 6 * 65536);
               if ($urandom_range(0, 1)) v = -v;
            end else begin
               v = $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
            end
         end
         1: v = $urandom;
         default: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = '0;
               3: v = -1;
               4: v = ONE;
               default: v = -ONE;
            endcase
         end
      endcase
      return v;
   endfunction

   // Check each result against the oldest expected one.
   always @(posedge clock) begin
      solution_type w;
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tridiagonal_system_solver_unit_test NOT OK");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         solutions_seen++;
         if (pending_solutions.size() == 0) begin
            $display("unexpected result at cycle %0d", cycles);
            errors++;
         end else begin
            w = pending_solutions.pop_front();
            if (rsp_solution !== w.solution)
               report_mismatch("solution", rsp_solution, w.solution);
            if (rsp_unknown_index !== w.index)
               report_mismatch("unknown_index", rsp_unknown_index, w.index);
            if (rsp_last_value !== w.last)
               report_mismatch("last_value", rsp_last_value, w.last);
            if (rsp_status !== w.status)
               report_mismatch("status", rsp_status, w.status);
            if (w.last) begin
               systems_solved++;
               if (w.status != STATUS_OK) error_runs++;
            end
         end
      end
   end

   initial begin
      row_type directed[$];
      row_type r;
      logic [DATA_W-1:0] lbs[5];
      logic [DATA_W-1:0] rbs[5];
      int size, bad_row, mode, quota;

      left_bound = 64'sd65536;
      right_bound = 64'sd196608;
      rows_seen = 0;
      run_error = STATUS_OK;

      // Directed rows; a few have their results written out since they read off at a glance.
      // single unknown with unit diagonal: x = rhs
      directed.push_back('{'0, ONE, '0, 5 * ONE, 1, 1, 5 * ONE, STATUS_OK});
      // zero pivot on a lone row
      directed.push_back('{'0, '0, '0, '0, 1, 1, '0, STATUS_PIVOT});
      // both reset boundaries fold in: x = 0 - 1.0 - 3.0
      directed.push_back('{ONE, ONE, ONE, '0, 1, 1, -4 * ONE, STATUS_OK});
      // extremes of every field, two-row system
      directed.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           0, 0, '0, STATUS_OK});
      directed.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                           1, 0, '0, STATUS_OK});
      // small diagonally dominant system of three
      directed.push_back('{-ONE, 4 * ONE, -ONE, ONE, 0, 0, '0, STATUS_OK});
      directed.push_back('{-ONE, 4 * ONE, -ONE, 2 * ONE, 0, 0, '0, STATUS_OK});
      directed.push_back('{-ONE, 4 * ONE, -ONE, 3 * ONE, 1, 0, '0, STATUS_OK});
      // zero pivot in the middle; the sweep goes on and the run ends in one status result
      directed.push_back('{ONE, 2 * ONE, ONE, ONE, 0, 0, '0, STATUS_OK});
      directed.push_back('{'0, '0, ONE, ONE, 0, 0, '0, STATUS_OK});
      directed.push_back('{ONE, 2 * ONE, ONE, ONE, 1, 1, '0, STATUS_PIVOT});
      // tiny pivot drives the quotient into saturation
      directed.push_back('{'0, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, '0, STATUS_OK});
      directed.push_back('{ONE, 32'sh7FFF_FFFF, -1, -1, 1, 0, '0, STATUS_OK});
      // negative unit diagonal and fractions
      directed.push_back('{32'sd32768, -ONE, -32'sd32768, 32'sd1, 1, 0, '0, STATUS_OK});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_row(directed[k]);

      // Boundary settings per phase: reset values, both extremes, zero, random.
      lbs = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, $urandom};
      rbs = '{32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, $urandom};
      quota = RANDOM_ROWS / 5;

      for (int ph = 0; ph < 5; ph++) begin
         wait_idle();
         set_boundaries(lbs[ph], rbs[ph]);
         for (int sent = 0; sent < quota; ) begin
            // Mostly small systems; now and then a full one or one that overruns.
            case ($urandom_range(0, 19))
               0, 1: size = $urandom_range(7, N_UNK - 1);
               2:    size = N_UNK;
               3:    size = $urandom_range(N_UNK + 1, N_UNK + 3);
               default: size = $urandom_range(1, 6);
            endcase
            bad_row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, size - 1) : -1;
            mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
            for (int i = 0; i < size; i++) begin
               r.sub = pick_coef(mode, 0);
               r.diag = pick_coef(mode, 1);
               r.sup = pick_coef(mode, 0);
               r.rhs = ($urandom_range(0, 9) == 0) ? $urandom : pick_coef(mode, 0);
               r.last = (i == size - 1);
               r.typed = 0;
               r.x = '0;
               r.status = STATUS_OK;
               if (i == bad_row) begin
                  r.sub = '0;
                  r.diag = '0;
               end
               send_row(r);
               sent++;
            end
         end
      end

      wait_idle();
      $display("covered %0d rows in %0d systems, %0d solutions, %0d error runs",
               rows_sent, systems_solved, solutions_seen, error_runs);
      $display("boundary settings: reset, both extremes, zero and random");
      if (errors == 0) begin
         $display("tridiagonal_system_solver_unit_test OK");
      end else begin
         $display("tridiagonal_system_solver_unit_test NOT OK");
      end
      $finish;
   end

endmodule
